FILE: design/k_smallest_selector_macros.svh
// assertion macros used by the k smallest selector controller
`ifndef K_SMALLEST_SELECTOR_MACROS_SVH
`define K_SMALLEST_SELECTOR_MACROS_SVH

// condition holds in the same cycle as the trigger
`define KSEL_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define KSEL_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/ksel_pkg.sv
// package with item types, command and status structs for the k smallest selector
`timescale 1ns / 1ps

package ksel_pkg;

    localparam int KEEP_COUNT = 10;
    localparam int VALUE_W    = 64;

    typedef struct packed {
        logic [VALUE_W-1:0] offer_value;
        logic               end_of_set;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] selected_value;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_ksel_cmd;

    typedef struct packed {
        logic head_valid;
        logic head_last;
    } t_ksel_status;

endpackage

FILE: design/ksel_datapath.sv
// sorted insertion cell row and output register of the k smallest selector
`timescale 1ns / 1ps

module ksel_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ksel_pkg::t_ksel_cmd   i_cmd,
    input  ksel_pkg::t_in_item    i_in_item,
    output ksel_pkg::t_ksel_status o_status,
    output ksel_pkg::t_out_item   o_out_item
);
    import ksel_pkg::*;

    logic [VALUE_W-1:0] r_vals [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] r_vld;
    t_out_item r_out;

    logic [VALUE_W-1:0] n_vals [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] n_vld;
    logic [VALUE_W-1:0] shin_vals [KEEP_COUNT];
    logic [VALUE_W-1:0] up_vals [KEEP_COUNT];
    logic [KEEP_COUNT:0] le_ext;
    logic [KEEP_COUNT:0] vld_prev_ext;
    logic [KEEP_COUNT:0] vld_up_ext;

    // per cell compare against the incoming value
    always_comb begin
        le_ext[0] = 1'b1;
        for (int i = 0; i < KEEP_COUNT; i++) begin
            le_ext[i+1] = r_vld[i] && (r_vals[i] <= i_in_item.offer_value);
        end
    end

    assign vld_prev_ext = {r_vld, 1'b1};
    assign vld_up_ext   = {1'b0, r_vld};

    always_comb begin
        shin_vals[0] = i_in_item.offer_value;
        for (int i = 1; i < KEEP_COUNT; i++) begin
            shin_vals[i] = r_vals[i-1];
        end
        up_vals[KEEP_COUNT-1] = '0;
        for (int i = 0; i < KEEP_COUNT - 1; i++) begin
            up_vals[i] = r_vals[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            n_vals[i] = r_vals[i];
            n_vld[i]  = r_vld[i];
            if (i_cmd.insert) begin
                if (!le_ext[i+1]) begin
                    n_vals[i] = le_ext[i] ? i_in_item.offer_value : shin_vals[i];
                end
                n_vld[i] = r_vld[i] | vld_prev_ext[i];
            end else if (i_cmd.pop) begin
                n_vals[i] = up_vals[i];
                n_vld[i]  = vld_up_ext[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            r_vals[i] <= n_vals[i];
        end
        if (i_cmd.pop) begin
            r_out.selected_value <= r_vals[0];
            r_out.last_of_run    <= !vld_up_ext[1];
        end
    end

    assign o_status.head_valid = r_vld[0];
    assign o_status.head_last  = !vld_up_ext[1];
    assign o_out_item          = r_out;

endmodule

FILE: design/ksel_ctrl.sv
// fill and emit controller of the k smallest selector
`timescale 1ns / 1ps
`include "k_smallest_selector_macros.svh"

module ksel_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_last,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  ksel_pkg::t_ksel_status i_status,
    output ksel_pkg::t_ksel_cmd    o_cmd
);
    import ksel_pkg::*;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == ST_FILL);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd.insert = 1'b0;
        o_cmd.pop    = 1'b0;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_FILL: begin
                o_cmd.insert = accept;
                if (accept && i_in_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && i_status.head_valid) begin
                    o_cmd.pop   = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.head_last) begin
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_FILL);
    assign o_out_valid = r_out_valid;

    `KSEL_ASSERT_NOW(a_emit_nonempty, r_state == ST_EMIT, i_status.head_valid, "emit with empty store")
    `KSEL_ASSERT_NEXT(a_flag_to_emit, accept && i_in_last, (r_state == ST_EMIT) && i_status.head_valid, "flagged item did not start emit")
    `KSEL_ASSERT_NEXT(a_last_to_fill, o_cmd.pop && i_status.head_last, (r_state == ST_FILL) && !i_status.head_valid, "store not empty after last item")

endmodule

FILE: design/k_smallest_selector.sv
// k smallest selector: usage notes
// input channel: i_in_valid / o_in_stall carry one offer value per item,
//   with end_of_set marking the final value of a data set
// output channel: o_out_valid / i_out_stall carry the retained values in
//   ascending order, last_of_run set on the final one of the set
// while a set is being filled one item is taken every cycle; each item is
//   placed in a row of KEEP_COUNT compare cells in the cycle it is accepted
// after the flagged item the store drains one item per cycle through the
//   output register while the output is not stalled; the flagged item moves
//   the controller to its emit state, whose first pop loads the first result,
//   and input is stalled until the last (at most KEEP_COUNT) value is popped
// per set: a fill phase for n values, then an emit phase of min(n, KEEP_COUNT)
//   values, paced by the single output register
// a stalled output holds its item; draining pauses until it is taken
// reset clears the cell valid bits and the output valid, leaving an empty
//   store ready to take an item
`timescale 1ns / 1ps

module k_smallest_selector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ksel_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ksel_pkg::t_out_item o_out_item
);
    import ksel_pkg::*;

    t_ksel_cmd    cmd;
    t_ksel_status status;

    ksel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_item.end_of_set),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ksel_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
